// ----- design/host_heartbeat_lease_watchdog_macros.svh -----
// Assertion macros used by the heartbeat lease watchdog core.
`ifndef HOST_HEARTBEAT_LEASE_WATCHDOG_MACROS_SVH
`define HOST_HEARTBEAT_LEASE_WATCHDOG_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define HLW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hlw: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define HLW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hlw: next-cycle check failed");

`endif

// ----- design/hlw_pkg.sv -----
// Types, codes and reset values for the heartbeat lease watchdog.
package hlw_pkg;

    // Event kinds carried by an input item
    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_BEAT       = 3'd1,
        KIND_ARM        = 3'd2,
        KIND_RENEW      = 3'd3,
        KIND_DISARM     = 3'd4,
        KIND_INVALIDATE = 3'd5,
        KIND_RESTART    = 3'd6
    } kind_t;

    // Reason codes reported with each result item
    typedef enum logic [2:0] {
        RC_OK           = 3'd0,
        RC_HOST_TIMEOUT = 3'd1,
        RC_NOT_ARMED    = 3'd2,
        RC_LEASE_EXPIRED = 3'd3,
        RC_BACKEND      = 3'd4
    } reason_t;

    // Configuration register indexes (byte address bits [3:2])
    typedef enum logic [1:0] {
        REG_HB_TIMEOUT    = 2'd0,
        REG_DEFAULT_LEASE = 2'd1,
        REG_MAX_LEASE     = 2'd2
    } reg_idx_t;

    localparam logic [15:0] HB_TIMEOUT_RST    = 16'd300;
    localparam logic [15:0] DEFAULT_LEASE_RST = 16'd500;
    localparam logic [15:0] MAX_LEASE_RST     = 16'd2000;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Configuration handed from the register block to the core
    typedef struct packed {
        logic [15:0] heartbeat_timeout;
        logic [15:0] default_lease;
        logic [15:0] max_lease;
    } cfg_t;

endpackage

// ----- design/host_heartbeat_lease_watchdog.sv -----
// Top level of the host heartbeat and lease watchdog.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  kind, now_time, lease_request, sink_ready
//   m_        out        m_valid / m_ready  reason_code, accepted, armed_now, heartbeat_age,
//                                           lease_remaining, max_gap, timeout_total, epoch
//   apb       in         psel/penable/pready heartbeat_timeout, default_lease, max_lease
//
// One item per cycle sustained while m_ready stays high; an item accepted on s_ passes
// through the input register and then the result register, the state update sitting
// between them, before it is presented on m_.
// Reset (aresetn low, synchronous) empties both registers, clears the state and
// loads the register defaults. A stall on m_ holds the result and then the input
// register; s_ready falls only when both are full and m_ready is low.
module host_heartbeat_lease_watchdog
    import hlw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_now_time,
    input  logic [15:0] s_lease_request,
    input  logic        s_sink_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reason_code,
    output logic        m_accepted,
    output logic        m_armed_now,
    output logic [31:0] m_heartbeat_age,
    output logic [31:0] m_lease_remaining,
    output logic [31:0] m_max_gap,
    output logic [31:0] m_timeout_total,
    output logic [31:0] m_epoch
);

    cfg_t cfg;

    // Configuration registers
    hlw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Event processing
    hlw_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_now_time        (s_now_time),
        .s_lease_request   (s_lease_request),
        .s_sink_ready      (s_sink_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reason_code     (m_reason_code),
        .m_accepted        (m_accepted),
        .m_armed_now       (m_armed_now),
        .m_heartbeat_age   (m_heartbeat_age),
        .m_lease_remaining (m_lease_remaining),
        .m_max_gap         (m_max_gap),
        .m_timeout_total   (m_timeout_total),
        .m_epoch           (m_epoch)
    );

endmodule

// ----- design/hlw_regs.sv -----
// APB configuration registers of the heartbeat lease watchdog.
module hlw_regs
    import hlw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] hb_timeout_reg;
    logic [15:0] default_lease_reg;
    logic [15:0] max_lease_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_timeout_reg    <= HB_TIMEOUT_RST;
            default_lease_reg <= DEFAULT_LEASE_RST;
            max_lease_reg     <= MAX_LEASE_RST;
        end else if (wr_en) begin
            case (idx)
                REG_HB_TIMEOUT:    hb_timeout_reg    <= pwdata[15:0];
                REG_DEFAULT_LEASE: default_lease_reg <= pwdata[15:0];
                REG_MAX_LEASE:     max_lease_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero beyond the list
    always_comb begin
        case (idx)
            REG_HB_TIMEOUT:    prdata = {16'd0, hb_timeout_reg};
            REG_DEFAULT_LEASE: prdata = {16'd0, default_lease_reg};
            REG_MAX_LEASE:     prdata = {16'd0, max_lease_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.heartbeat_timeout = hb_timeout_reg;
    assign cfg.default_lease     = default_lease_reg;
    assign cfg.max_lease         = max_lease_reg;

endmodule

// ----- design/hlw_core.sv -----
// Event stage: input register, watchdog state update and result register.
module hlw_core
    import hlw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_now_time,
    input  logic [15:0] s_lease_request,
    input  logic        s_sink_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_reason_code,
    output logic        m_accepted,
    output logic        m_armed_now,
    output logic [31:0] m_heartbeat_age,
    output logic [31:0] m_lease_remaining,
    output logic [31:0] m_max_gap,
    output logic [31:0] m_timeout_total,
    output logic [31:0] m_epoch
);

    // Input register
    logic        in_valid_reg;
    logic [2:0]  in_kind_reg;
    logic [31:0] in_now_reg;
    logic [15:0] in_req_reg;
    logic        in_ready_reg;

    // Watchdog state
    logic        seen_reg, seen_next;
    logic        armed_reg, armed_next;
    logic [31:0] last_beat_reg, last_beat_next;
    logic [31:0] gap_reg, gap_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] tmo_cnt_reg, tmo_cnt_next;
    logic [31:0] epoch_reg, epoch_next;

    // Result register
    logic        out_valid_reg;
    logic [2:0]  out_reason_reg;
    logic        out_accepted_reg;
    logic        out_armed_reg;
    logic [31:0] out_age_reg;
    logic [31:0] out_rem_reg;

    logic        advance;
    logic [31:0] age_pre;
    logic [31:0] rem_pre;
    logic        beat_alive_pre;
    logic        lease_alive_pre;
    logic [15:0] norm_lease;
    logic [31:0] new_deadline;
    logic        last_set;
    logic [1:0]  dl_mode;
    logic        has_code;
    reason_t     code;
    reason_t     acc_rc;
    logic [31:0] age_post;
    logic [31:0] rem_post;
    logic        beat_alive_post;
    logic        lease_alive_post;
    logic        result_sane;
    logic        arm_taken;
    logic        tmo_hold;

    localparam logic [1:0] DL_KEEP = 2'd0;
    localparam logic [1:0] DL_NOW  = 2'd1;
    localparam logic [1:0] DL_NEW  = 2'd2;

    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    // Hold the accepted item until it moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_now_reg   <= s_now_time;
            in_req_reg   <= s_lease_request;
            in_ready_reg <= s_sink_ready;
        end
    end

    // Liveness before the event
    assign age_pre         = in_now_reg - last_beat_reg;
    assign rem_pre         = deadline_reg - in_now_reg;
    assign beat_alive_pre  = seen_reg && (age_pre <= {16'd0, cfg.heartbeat_timeout});
    assign lease_alive_pre = armed_reg && (rem_pre != 32'd0) && !rem_pre[31];

    // Normalize the requested lease
    always_comb begin
        if (in_req_reg == 16'd0) begin
            norm_lease = cfg.default_lease;
        end else if (in_req_reg > cfg.max_lease) begin
            norm_lease = cfg.max_lease;
        end else begin
            norm_lease = in_req_reg;
        end
    end

    assign new_deadline = in_now_reg + {16'd0, norm_lease};

    // Apply the event to the state
    always_comb begin
        seen_next     = seen_reg;
        armed_next    = armed_reg;
        last_beat_next = last_beat_reg;
        gap_next      = gap_reg;
        deadline_next = deadline_reg;
        tmo_cnt_next  = tmo_cnt_reg;
        epoch_next    = epoch_reg;
        last_set      = 1'b0;
        dl_mode       = DL_KEEP;
        has_code      = 1'b0;
        code          = RC_OK;
        case (in_kind_reg)
            KIND_TICK: begin
                if (armed_reg && (!beat_alive_pre || !lease_alive_pre)) begin
                    armed_next    = 1'b0;
                    deadline_next = in_now_reg;
                    dl_mode       = DL_NOW;
                    if (tmo_cnt_reg != ALL_ONES) begin
                        tmo_cnt_next = tmo_cnt_reg + 32'd1;
                    end
                end
            end
            KIND_BEAT: begin
                if (seen_reg && (age_pre > gap_reg)) begin
                    gap_next = age_pre;
                end
                seen_next      = 1'b1;
                last_beat_next = in_now_reg;
                last_set       = 1'b1;
            end
            KIND_ARM: begin
                has_code = 1'b1;
                if (!beat_alive_pre) begin
                    code = RC_HOST_TIMEOUT;
                end else if (!in_ready_reg) begin
                    code = RC_BACKEND;
                end else begin
                    armed_next    = 1'b1;
                    deadline_next = new_deadline;
                    dl_mode       = DL_NEW;
                    epoch_next    = (epoch_reg == ALL_ONES) ? 32'd1 : epoch_reg + 32'd1;
                end
            end
            KIND_RENEW: begin
                has_code = 1'b1;
                if (!beat_alive_pre) begin
                    armed_next    = 1'b0;
                    deadline_next = in_now_reg;
                    dl_mode       = DL_NOW;
                    code          = RC_HOST_TIMEOUT;
                end else if (!armed_reg) begin
                    code = RC_NOT_ARMED;
                end else begin
                    deadline_next = new_deadline;
                    dl_mode       = DL_NEW;
                end
            end
            KIND_DISARM: begin
                armed_next    = 1'b0;
                deadline_next = in_now_reg;
                dl_mode       = DL_NOW;
            end
            KIND_INVALIDATE: begin
                seen_next      = 1'b0;
                armed_next     = 1'b0;
                deadline_next  = in_now_reg;
                dl_mode        = DL_NOW;
                last_beat_next = in_now_reg;
                last_set       = 1'b1;
            end
            KIND_RESTART: begin
                seen_next      = 1'b0;
                armed_next     = 1'b0;
                last_beat_next = in_now_reg;
                last_set       = 1'b1;
                gap_next       = 32'd0;
                deadline_next  = in_now_reg;
                dl_mode        = DL_NOW;
                tmo_cnt_next   = 32'd0;
                epoch_next     = 32'd0;
            end
            default: ;
        endcase
    end

    // Liveness after the event, derived from the pre-event differences
    always_comb begin
        if (!seen_next) begin
            age_post = ALL_ONES;
        end else if (last_set) begin
            age_post = 32'd0;
        end else begin
            age_post = age_pre;
        end
        case (dl_mode)
            DL_NOW:  rem_post = 32'd0;
            DL_NEW:  rem_post = {16'd0, norm_lease};
            default: rem_post = rem_pre;
        endcase
    end

    assign beat_alive_post  = seen_next && (age_post <= {16'd0, cfg.heartbeat_timeout});
    assign lease_alive_post = armed_next && (rem_post != 32'd0) && !rem_post[31];

    // Rank the acceptance conditions
    always_comb begin
        if (!beat_alive_post) begin
            acc_rc = RC_HOST_TIMEOUT;
        end else if (!armed_next) begin
            acc_rc = RC_NOT_ARMED;
        end else if (!lease_alive_post) begin
            acc_rc = RC_LEASE_EXPIRED;
        end else if (!in_ready_reg) begin
            acc_rc = RC_BACKEND;
        end else begin
            acc_rc = RC_OK;
        end
    end

    // Advance the state once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            last_beat_reg <= 32'd0;
            gap_reg       <= 32'd0;
            deadline_reg  <= 32'd0;
            tmo_cnt_reg   <= 32'd0;
            epoch_reg     <= 32'd0;
        end else if (advance) begin
            seen_reg      <= seen_next;
            armed_reg     <= armed_next;
            last_beat_reg <= last_beat_next;
            gap_reg       <= gap_next;
            deadline_reg  <= deadline_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            epoch_reg     <= epoch_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reason_reg   <= has_code ? code : acc_rc;
            out_accepted_reg <= (acc_rc == RC_OK);
            out_armed_reg    <= armed_next;
            out_age_reg      <= age_post;
            out_rem_reg      <= lease_alive_post ? rem_post : 32'd0;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_reason_code     = out_reason_reg;
    assign m_accepted        = out_accepted_reg;
    assign m_armed_now       = out_armed_reg;
    assign m_heartbeat_age   = out_age_reg;
    assign m_lease_remaining = out_rem_reg;
    assign m_max_gap         = gap_reg;
    assign m_timeout_total   = tmo_cnt_reg;
    assign m_epoch           = epoch_reg;

    `include "host_heartbeat_lease_watchdog_macros.svh"

    assign result_sane = m_armed_now && (m_lease_remaining != 32'd0)
                         && (m_heartbeat_age != ALL_ONES);
    assign arm_taken   = advance && (in_kind_reg == KIND_ARM) && armed_next && !armed_reg;
    assign tmo_hold    = advance && (in_kind_reg != KIND_RESTART);

    // An armed watchdog always has a heartbeat on record
    `HLW_ASSERT_NOW(a_armed_has_beat, aclk, aresetn, armed_reg, seen_reg)

    // An accepted result comes with an armed flag, a live lease and a beat
    `HLW_ASSERT_NOW(a_accept_consistent, aclk, aresetn, m_valid && m_accepted, result_sane)

    // A successful arm never leaves the epoch at zero
    `HLW_ASSERT_NEXT(a_epoch_nonzero, aclk, aresetn, arm_taken, epoch_reg != 32'd0)

    // Only a restart lowers the timeout count
    `HLW_ASSERT_NEXT(a_tmo_monotonic, aclk, aresetn, tmo_hold, tmo_cnt_reg >= $past(tmo_cnt_reg))

endmodule

// ----- verif/hlw_result_checker.sv -----
// Result checker for the heartbeat lease watchdog: tracks its state and compares each result.
`timescale 1ns / 1ps

module hlw_result_checker
    import hlw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_now_time,
    input  logic [15:0] s_lease_request,
    input  logic        s_sink_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_reason_code,
    input  logic        m_accepted,
    input  logic        m_armed_now,
    input  logic [31:0] m_heartbeat_age,
    input  logic [31:0] m_lease_remaining,
    input  logic [31:0] m_max_gap,
    input  logic [31:0] m_timeout_total,
    input  logic [31:0] m_epoch,
    output int unsigned mismatch_count,
    output int unsigned open_reports
);

    // One status report, laid out in the order of the result ports
    typedef struct packed {
        logic [2:0]  reason;
        logic        accepted;
        logic        armed;
        logic [31:0] age;
        logic [31:0] remaining;
        logic [31:0] gap;
        logic [31:0] timeouts;
        logic [31:0] epoch;
    } wd_report_t;

    // Mirrored registers and watchdog state
    cfg_t        cfg;
    logic        beat_seen;
    logic        armed;
    logic [31:0] last_beat;
    logic [31:0] widest_gap;
    logic [31:0] deadline;
    logic [31:0] timeout_cnt;
    logic [31:0] epoch_cnt;

    wd_report_t  predicted_reports[$];
    int unsigned errors = 0;

    assign mismatch_count = errors;

    function automatic logic beat_live(input logic [31:0] now);
        logic [31:0] age;
        age = now - last_beat;
        return beat_seen && (age <= {16'h0, cfg.heartbeat_timeout});
    endfunction

    // Alive while deadline - now is positive as a signed 32-bit value
    function automatic logic lease_live(input logic [31:0] now);
        logic [31:0] left;
        left = deadline - now;
        return armed && (left != 32'd0) && !left[31];
    endfunction

    // Zero takes the default (never clamped), anything else is clamped to max
    function automatic logic [31:0] lease_len(input logic [15:0] req);
        if (req == 16'd0)
            return {16'h0, cfg.default_lease};
        return (req > cfg.max_lease) ? {16'h0, cfg.max_lease} : {16'h0, req};
    endfunction

    // First failing condition in priority order
    function automatic logic [2:0] gate_reason(input logic [31:0] now, input logic rdy);
        if (!beat_live(now))
            return RC_HOST_TIMEOUT;
        if (!armed)
            return RC_NOT_ARMED;
        if (!lease_live(now))
            return RC_LEASE_EXPIRED;
        if (!rdy)
            return RC_BACKEND;
        return RC_OK;
    endfunction

    function automatic void drop_lease(input logic [31:0] now);
        armed    = 1'b0;
        deadline = now;
    endfunction

    // Apply one event to the mirrored state and return the report it yields
    function automatic wd_report_t apply_event(input logic [2:0] kind, input logic [31:0] now,
                                               input logic [15:0] req, input logic rdy);
        wd_report_t  rep;
        logic [2:0]  verdict;
        logic        has_verdict;
        logic [2:0]  gate;
        logic [31:0] gap;
        verdict     = RC_OK;
        has_verdict = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (armed && (!beat_live(now) || !lease_live(now))) begin
                    drop_lease(now);
                    if (timeout_cnt != ALL_ONES)
                        timeout_cnt = timeout_cnt + 32'd1;
                end
            end
            KIND_BEAT: begin
                if (beat_seen) begin
                    gap = now - last_beat;
                    if (gap > widest_gap)
                        widest_gap = gap;
                end
                beat_seen = 1'b1;
                last_beat = now;
            end
            KIND_ARM: begin
                has_verdict = 1'b1;
                if (!beat_live(now)) begin
                    verdict = RC_HOST_TIMEOUT;
                end else if (!rdy) begin
                    verdict = RC_BACKEND;
                end else begin
                    armed     = 1'b1;
                    deadline  = now + lease_len(req);
                    epoch_cnt = epoch_cnt + 32'd1;
                    if (epoch_cnt == 32'd0)
                        epoch_cnt = 32'd1;
                    verdict = RC_OK;
                end
            end
            KIND_RENEW: begin
                has_verdict = 1'b1;
                if (!beat_live(now)) begin
                    drop_lease(now);
                    verdict = RC_HOST_TIMEOUT;
                end else if (!armed) begin
                    verdict = RC_NOT_ARMED;
                end else begin
                    deadline = now + lease_len(req);
                    verdict  = RC_OK;
                end
            end
            KIND_DISARM: begin
                drop_lease(now);
            end
            KIND_INVALIDATE: begin
                beat_seen = 1'b0;
                drop_lease(now);
                last_beat = now;
            end
            KIND_RESTART: begin
                beat_seen   = 1'b0;
                armed       = 1'b0;
                last_beat   = now;
                widest_gap  = 32'd0;
                deadline    = now;
                timeout_cnt = 32'd0;
                epoch_cnt   = 32'd0;
            end
            default: ;
        endcase

        gate          = gate_reason(now, rdy);
        rep.reason    = has_verdict ? verdict : gate;
        rep.accepted  = (gate == RC_OK);
        rep.armed     = armed;
        rep.age       = beat_seen ? now - last_beat : ALL_ONES;
        rep.remaining = lease_live(now) ? deadline - now : 32'd0;
        rep.gap       = widest_gap;
        rep.timeouts  = timeout_cnt;
        rep.epoch     = epoch_cnt;
        return rep;
    endfunction

    // Track register writes, predict on each input item, compare on each result item
    always @(posedge aclk) begin : track
        wd_report_t want;
        wd_report_t got;
        if (!aresetn) begin
            cfg.heartbeat_timeout = HB_TIMEOUT_RST;
            cfg.default_lease     = DEFAULT_LEASE_RST;
            cfg.max_lease         = MAX_LEASE_RST;
            beat_seen   = 1'b0;
            armed       = 1'b0;
            last_beat   = 32'd0;
            widest_gap  = 32'd0;
            deadline    = 32'd0;
            timeout_cnt = 32'd0;
            epoch_cnt   = 32'd0;
            predicted_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_HB_TIMEOUT:    cfg.heartbeat_timeout = pwdata[15:0];
                    REG_DEFAULT_LEASE: cfg.default_lease     = pwdata[15:0];
                    REG_MAX_LEASE:     cfg.max_lease         = pwdata[15:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                predicted_reports.push_back(apply_event(s_kind, s_now_time,
                                                        s_lease_request, s_sink_ready));

            if (m_valid && m_ready) begin
                got = {m_reason_code, m_accepted, m_armed_now, m_heartbeat_age,
                       m_lease_remaining, m_max_gap, m_timeout_total, m_epoch};
                if (predicted_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("hlw: result item at %0t with no report outstanding", $time);
                end else begin
                    want = predicted_reports.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("hlw: result mismatch at %0t (expected / actual)", $time);
                            $display("  reason %0d / %0d  accepted %0b / %0b  armed %0b / %0b",
                                     want.reason, got.reason, want.accepted, got.accepted,
                                     want.armed, got.armed);
                            $display("  age %h / %h  remaining %h / %h  max_gap %h / %h",
                                     want.age, got.age, want.remaining, got.remaining,
                                     want.gap, got.gap);
                            $display("  timeouts %h / %h  epoch %h / %h",
                                     want.timeouts, got.timeouts, want.epoch, got.epoch);
                        end
                    end
                end
            end
        end
        open_reports <= predicted_reports.size();
    end

endmodule

// ----- verif/host_heartbeat_lease_watchdog_tb.sv -----
// Testbench top for the heartbeat lease watchdog: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module host_heartbeat_lease_watchdog_tb;
    import hlw_pkg::*;

    localparam logic [2:0] KIND_UNUSED       = 3'd7;
    localparam int         NUM_PROFILES      = 6;
    localparam int         ITEMS_PER_PROFILE = 290;
    localparam int         LONG_HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES      = 8;
    // Time limit for the whole run, well above the worst case
    localparam int         RUN_LIMIT_NS      = 6_000_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic [31:0] s_now_time;
    logic [15:0] s_lease_request;
    logic        s_sink_ready;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_reason_code;
    logic        m_accepted;
    logic        m_armed_now;
    logic [31:0] m_heartbeat_age;
    logic [31:0] m_lease_remaining;
    logic [31:0] m_max_gap;
    logic [31:0] m_timeout_total;
    logic [31:0] m_epoch;

    int unsigned mismatch_count;
    int unsigned open_reports;

    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          rx_hold_req = 1'b0;
    cfg_t        active_cfg;
    logic [31:0] now_ms;

    always #6 aclk = ~aclk;

    host_heartbeat_lease_watchdog dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_now_time        (s_now_time),
        .s_lease_request   (s_lease_request),
        .s_sink_ready      (s_sink_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reason_code     (m_reason_code),
        .m_accepted        (m_accepted),
        .m_armed_now       (m_armed_now),
        .m_heartbeat_age   (m_heartbeat_age),
        .m_lease_remaining (m_lease_remaining),
        .m_max_gap         (m_max_gap),
        .m_timeout_total   (m_timeout_total),
        .m_epoch           (m_epoch)
    );

    hlw_result_checker report_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_now_time        (s_now_time),
        .s_lease_request   (s_lease_request),
        .s_sink_ready      (s_sink_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reason_code     (m_reason_code),
        .m_accepted        (m_accepted),
        .m_armed_now       (m_armed_now),
        .m_heartbeat_age   (m_heartbeat_age),
        .m_lease_remaining (m_lease_remaining),
        .m_max_gap         (m_max_gap),
        .m_timeout_total   (m_timeout_total),
        .m_epoch           (m_epoch),
        .mismatch_count    (mismatch_count),
        .open_reports      (open_reports)
    );

    // Register settings for the random phases, extremes among them
    function automatic cfg_t lease_profile(input int p);
        cfg_t c;
        case (p)
            0:       c = '{16'd0,     16'd1,     16'd1};
            1:       c = '{16'd65535, 16'd65535, 16'd65535};
            2:       c = '{16'd40,    16'd0,     16'd30};
            3:       c = '{16'd1000,  16'd3000,  16'd100};
            4:       c = '{16'd7,     16'd20,    16'd12};
            default: c = '{HB_TIMEOUT_RST, DEFAULT_LEASE_RST, MAX_LEASE_RST};
        endcase
        return c;
    endfunction

    // Offer one event, after an optional idle burst, and hold it until taken
    task automatic post_event(input logic [2:0] kind, input logic [31:0] t,
                              input logic [15:0] req, input logic rdy);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_now_time      <= t;
        s_lease_request <= req;
        s_sink_ready    <= rdy;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every report has come back
    task automatic await_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_reports != 0);
    endtask

    // Setup and access cycle, then idle before the next transfer
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly live sessions on an advancing clock, with jumps and stray timestamps
    task automatic random_event();
        int unsigned r;
        int unsigned span;
        logic [31:0] t;
        logic [2:0]  kind;
        logic [15:0] req;
        span = active_cfg.heartbeat_timeout + 1;
        r    = $urandom_range(0, 99);
        if (r < 15)
            now_ms = now_ms;
        else if (r < 70)
            now_ms = now_ms + $urandom_range(0, span / 3 + 1);
        else if (r < 92)
            now_ms = now_ms + $urandom_range(0, span + active_cfg.max_lease);
        else if (r < 97)
            now_ms = now_ms + $urandom;
        t = (r >= 97) ? $urandom : now_ms;

        r = $urandom_range(0, 99);
        if (r < 28)      kind = KIND_BEAT;
        else if (r < 50) kind = KIND_TICK;
        else if (r < 64) kind = KIND_ARM;
        else if (r < 80) kind = KIND_RENEW;
        else if (r < 86) kind = KIND_DISARM;
        else if (r < 91) kind = KIND_INVALIDATE;
        else if (r < 95) kind = KIND_RESTART;
        else             kind = KIND_UNUSED;

        r = $urandom_range(0, 99);
        if (r < 20)
            req = 16'd0;
        else if (r < 70)
            req = 16'($urandom_range(1, active_cfg.max_lease + 16));
        else
            req = 16'($urandom);

        post_event(kind, t, req, $urandom_range(0, 9) != 0);
    endtask

    // Receiver: random stall bursts, one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                m_ready     <= 1'b1;
                rx_hold_req <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("** host_heartbeat_lease_watchdog: FAILED **");
        $finish;
    end

    initial begin
        int   p;
        int   i;
        cfg_t prof;
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 4'd0;
        pwdata          = 32'd0;
        s_valid         = 1'b0;
        s_kind          = KIND_TICK;
        s_now_time      = 32'd0;
        s_lease_request = 16'd0;
        s_sink_ready    = 1'b0;
        active_cfg      = '{HB_TIMEOUT_RST, DEFAULT_LEASE_RST, MAX_LEASE_RST};
        now_ms          = 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events under the reset settings
        post_event(KIND_TICK,       32'd0,   16'd0,    1'b1); // nothing seen yet
        post_event(KIND_ARM,        32'd10,  16'd0,    1'b1); // refused, no heartbeat
        post_event(KIND_RENEW,      32'd20,  16'd0,    1'b1); // renew with no heartbeat
        post_event(KIND_BEAT,       32'd100, 16'd0,    1'b1);
        post_event(KIND_RENEW,      32'd150, 16'd0,    1'b1); // not armed
        post_event(KIND_ARM,        32'd200, 16'd0,    1'b0); // backend not ready
        post_event(KIND_ARM,        32'd250, 16'd0,    1'b1); // default lease
        post_event(KIND_TICK,       32'd260, 16'd0,    1'b0); // backend down at acceptance
        post_event(KIND_RENEW,      32'd300, 16'hFFFF, 1'b1); // clamped to max
        post_event(KIND_RENEW,      32'd350, 16'd1,    1'b1);
        post_event(KIND_TICK,       32'd351, 16'd0,    1'b1); // lease ends exactly now
        post_event(KIND_BEAT,       32'd400, 16'd0,    1'b1);
        post_event(KIND_ARM,        32'd700, 16'd100,  1'b1); // age equals timeout
        post_event(KIND_TICK,       32'd701, 16'd0,    1'b1); // heartbeat just died
        post_event(KIND_UNUSED,     32'd702, 16'hFFFF, 1'b1);
        post_event(KIND_BEAT,       32'd800, 16'd0,    1'b1);
        post_event(KIND_ARM,        32'd810, 16'd0,    1'b1);
        post_event(KIND_DISARM,     32'd820, 16'd0,    1'b1);
        post_event(KIND_BEAT,       32'd830, 16'd0,    1'b1);
        post_event(KIND_INVALIDATE, 32'd850, 16'd0,    1'b1);
        // Session across the timestamp wrap, then a far jump
        post_event(KIND_RESTART,    32'hFFFF_FF00, 16'd0,    1'b1);
        post_event(KIND_BEAT,       32'hFFFF_FF10, 16'd0,    1'b1);
        post_event(KIND_ARM,        32'hFFFF_FF20, 16'd2000, 1'b1);
        post_event(KIND_BEAT,       32'h0000_0010, 16'd0,    1'b1);
        post_event(KIND_TICK,       32'h0000_0020, 16'd0,    1'b1);
        post_event(KIND_TICK,       32'h9000_0020, 16'd0,    1'b1);

        // Random phases, one register setting each
        for (p = 0; p < NUM_PROFILES; p++) begin
            await_results();
            prof = lease_profile(p);
            write_reg(REG_HB_TIMEOUT, prof.heartbeat_timeout);
            write_reg(REG_DEFAULT_LEASE, prof.default_lease);
            write_reg(REG_MAX_LEASE, prof.max_lease);
            active_cfg = prof;
            now_ms     = p[0] ? 32'hFFFF_FFFF - $urandom_range(0, 40000) : $urandom;
            tx_idle_on = (p == 0) || ($urandom_range(0, 3) != 0);
            rx_idle_on <= (p == 0) || ($urandom_range(0, 3) != 0);
            for (i = 0; i < ITEMS_PER_PROFILE; i++) begin
                // Stall the receiver for long while items keep coming
                if (p == 0 && i == 60)
                    rx_hold_req <= 1'b1;
                // Let the pipeline empty before going on
                if (p == 2 && i == 140)
                    await_results();
                // Finish at full rate on both sides
                if (p == NUM_PROFILES - 1 && i == 190) begin
                    tx_idle_on = 1'b0;
                    rx_idle_on <= 1'b0;
                end
                random_event();
            end
        end

        await_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && open_reports == 0)
            $display("** host_heartbeat_lease_watchdog: PASSED **");
        else
            $display("** host_heartbeat_lease_watchdog: FAILED **");
        $finish;
    end

endmodule
